FILE: rtl/core/world_point_screen_projection_assert.svh
// assertion helpers, sampled on clk, quiet during reset
`ifndef WORLD_POINT_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_POINT_SCREEN_PROJECTION_ASSERT_SVH

`define WPSP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define WPSP_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/wpsp_pkg.sv
package wpsp_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int SCREEN_BITS = 12;

    localparam int AXIS_W   = 16;
    localparam int AXIS_FRAC = 14;
    localparam int RECIP_W  = 24;
    localparam int SIZE_W   = 12;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 4;

    localparam logic [SIZE_W-1:0] VIRTUAL_W = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] VIRTUAL_H = SIZE_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X      = 4'd0,
        REG_ORIGIN_Y      = 4'd1,
        REG_ORIGIN_Z      = 4'd2,
        REG_AXIS_FORWARD  = 4'd3,
        REG_AXIS_RIGHT    = 4'd4,
        REG_AXIS_UP       = 4'd5,
        REG_INV_TAN       = 4'd6,
        REG_VIEWPORT_SIZE = 4'd7
    } wpsp_reg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          use_virtual_screen;
    } wpsp_in_t;

    typedef struct packed {
        logic                   on_screen;
        logic [SCREEN_BITS-1:0] screen_x;
        logic [SCREEN_BITS-1:0] screen_y;
    } wpsp_out_t;

endpackage

FILE: rtl/core/world_point_screen_projection.sv
// Projects one world point per clock onto the screen. A beat is taken at every edge where
// start is high (busy is always low) and its result appears on result with done high, one
// per cycle, in order. The receiver cannot stall, so nothing here ever holds a result back.
// Each point passes through five arithmetic stages (offset, axis products, dot sums,
// reciprocal scaling, bounds test) followed by a twelve-stage restoring divider that
// resolves one pixel bit per stage, then the output register. Configuration writes are
// always ready and take effect at once; they belong between streams.
module world_point_screen_projection
    import wpsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  wpsp_in_t             point,
    output logic                 done,
    output wpsp_out_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    `include "world_point_screen_projection_assert.svh"

    localparam int V_W    = COORD_WIDTH + 1;
    localparam int PROD_W = V_W + AXIS_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int D_W    = SUM_W - AXIS_FRAC;
    localparam int F_W    = D_W + 16;
    localparam int PL_W   = D_W + RECIP_W + 1;
    localparam int T_W    = PL_W + 1;
    localparam int REM_W  = D_W + 18;
    localparam int LATENCY = 18;

    // configuration
    logic signed [COORD_WIDTH-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [CFG_W-1:0] axis_fwd_reg, axis_right_reg, axis_up_reg, inv_tan_reg;
    logic [2*SIZE_W-1:0] viewport_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            origin_z_reg   <= '0;
            axis_fwd_reg   <= '0;
            axis_right_reg <= '0;
            axis_up_reg    <= '0;
            inv_tan_reg    <= CFG_W'(48'd1099511693312);
            viewport_reg   <= (2*SIZE_W)'(24'd2621920);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:      origin_x_reg   <= cfg_data[COORD_WIDTH-1:0];
                REG_ORIGIN_Y:      origin_y_reg   <= cfg_data[COORD_WIDTH-1:0];
                REG_ORIGIN_Z:      origin_z_reg   <= cfg_data[COORD_WIDTH-1:0];
                REG_AXIS_FORWARD:  axis_fwd_reg   <= cfg_data;
                REG_AXIS_RIGHT:    axis_right_reg <= cfg_data;
                REG_AXIS_UP:       axis_up_reg    <= cfg_data;
                REG_INV_TAN:       inv_tan_reg    <= cfg_data;
                REG_VIEWPORT_SIZE: viewport_reg   <= cfg_data[2*SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // stage 1: offset from view origin
    logic s1_valid_reg;
    logic signed [V_W-1:0] s1_vx_reg, s1_vy_reg, s1_vz_reg;
    logic s1_virt_reg;

    // stage 2: nine axis products
    logic s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [9];
    logic s2_virt_reg;

    // stage 3: dot products floored to Q.4
    logic s3_valid_reg;
    logic signed [D_W-1:0] s3_lat_reg, s3_fwd_reg, s3_vert_reg;
    logic s3_virt_reg;

    // stage 4: lateral distances times reciprocal tangents
    logic s4_valid_reg;
    logic signed [PL_W-1:0] s4_px_reg, s4_py_reg;
    logic [F_W-1:0] s4_f16_reg;
    logic s4_pos_reg;
    logic [SIZE_W-1:0] s4_w_reg, s4_h_reg;

    // stage 5: bounds test and divider operands
    logic s5_valid_reg, s5_ok_reg;
    logic [REM_W-1:0] s5_tx_reg, s5_ty_reg, s5_den_reg;
    logic [SIZE_W-1:0] s5_w_reg, s5_h_reg;

    // divider stages, one quotient bit each
    logic              dv_valid_reg [SIZE_W];
    logic              dv_ok_reg    [SIZE_W];
    logic [REM_W-1:0]  dv_tx_reg    [SIZE_W];
    logic [REM_W-1:0]  dv_ty_reg    [SIZE_W];
    logic [REM_W-1:0]  dv_den_reg   [SIZE_W];
    logic [REM_W-1:0]  dv_rx_reg    [SIZE_W];
    logic [REM_W-1:0]  dv_ry_reg    [SIZE_W];
    logic [SIZE_W-1:0] dv_qx_reg    [SIZE_W];
    logic [SIZE_W-1:0] dv_qy_reg    [SIZE_W];
    logic [SIZE_W-1:0] dv_w_reg     [SIZE_W];
    logic [SIZE_W-1:0] dv_h_reg     [SIZE_W];

    logic      out_valid_reg;
    wpsp_out_t out_reg;

    function automatic logic signed [AXIS_W-1:0] axis_comp(input logic [CFG_W-1:0] a,
                                                           input int k);
        return a[k*AXIS_W +: AXIS_W];
    endfunction

    // one restoring step: shift, reduce, add t when the size bit is set, reduce
    function automatic logic [REM_W+SIZE_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                         input logic [SIZE_W-1:0] q,
                                                         input logic [REM_W-1:0] t,
                                                         input logic [REM_W-1:0] den,
                                                         input logic bit_set);
        logic [REM_W-1:0] r;
        logic [SIZE_W-1:0] qn;
        r  = {rem[REM_W-2:0], 1'b0};
        qn = {q[SIZE_W-2:0], 1'b0};
        if (r >= den)
        begin
            r  = r - den;
            qn = qn + SIZE_W'(1);
        end
        if (bit_set)
        begin
            r = r + t;
            if (r >= den)
            begin
                r  = r - den;
                qn = qn + SIZE_W'(1);
            end
        end
        return {r, qn};
    endfunction

    logic signed [SUM_W-1:0] sum_lat, sum_fwd, sum_vert;
    logic signed [T_W-1:0] tx_full, ty_full, den_full;

    always_comb
    begin
        sum_lat  = SUM_W'(s2_prod_reg[0]) + SUM_W'(s2_prod_reg[1]) + SUM_W'(s2_prod_reg[2]);
        sum_fwd  = SUM_W'(s2_prod_reg[3]) + SUM_W'(s2_prod_reg[4]) + SUM_W'(s2_prod_reg[5]);
        sum_vert = SUM_W'(s2_prod_reg[6]) + SUM_W'(s2_prod_reg[7]) + SUM_W'(s2_prod_reg[8]);
        den_full = T_W'($signed({1'b0, s4_f16_reg, 1'b0}));
        tx_full  = T_W'($signed({1'b0, s4_f16_reg})) - T_W'(s4_px_reg);
        ty_full  = T_W'($signed({1'b0, s4_f16_reg})) - T_W'(s4_py_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SIZE_W; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg  <= start;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            dv_valid_reg[0] <= s5_valid_reg;
            for (int i = 1; i < SIZE_W; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            out_valid_reg <= dv_valid_reg[SIZE_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [REM_W+SIZE_W-1:0] sx, sy;

        s1_vx_reg   <= V_W'(point.point_x) - V_W'(origin_x_reg);
        s1_vy_reg   <= V_W'(point.point_y) - V_W'(origin_y_reg);
        s1_vz_reg   <= V_W'(point.point_z) - V_W'(origin_z_reg);
        s1_virt_reg <= point.use_virtual_screen;

        s2_prod_reg[0] <= PROD_W'(s1_vx_reg) * PROD_W'(axis_comp(axis_right_reg, 2));
        s2_prod_reg[1] <= PROD_W'(s1_vy_reg) * PROD_W'(axis_comp(axis_right_reg, 1));
        s2_prod_reg[2] <= PROD_W'(s1_vz_reg) * PROD_W'(axis_comp(axis_right_reg, 0));
        s2_prod_reg[3] <= PROD_W'(s1_vx_reg) * PROD_W'(axis_comp(axis_fwd_reg, 2));
        s2_prod_reg[4] <= PROD_W'(s1_vy_reg) * PROD_W'(axis_comp(axis_fwd_reg, 1));
        s2_prod_reg[5] <= PROD_W'(s1_vz_reg) * PROD_W'(axis_comp(axis_fwd_reg, 0));
        s2_prod_reg[6] <= PROD_W'(s1_vx_reg) * PROD_W'(axis_comp(axis_up_reg, 2));
        s2_prod_reg[7] <= PROD_W'(s1_vy_reg) * PROD_W'(axis_comp(axis_up_reg, 1));
        s2_prod_reg[8] <= PROD_W'(s1_vz_reg) * PROD_W'(axis_comp(axis_up_reg, 0));
        s2_virt_reg    <= s1_virt_reg;

        // arithmetic shift floors toward minus infinity
        s3_lat_reg  <= sum_lat[SUM_W-1:AXIS_FRAC];
        s3_fwd_reg  <= sum_fwd[SUM_W-1:AXIS_FRAC];
        s3_vert_reg <= sum_vert[SUM_W-1:AXIS_FRAC];
        s3_virt_reg <= s2_virt_reg;

        s4_px_reg  <= PL_W'(s3_lat_reg)
                      * PL_W'($signed({1'b0, inv_tan_reg[2*RECIP_W-1:RECIP_W]}));
        s4_py_reg  <= PL_W'(s3_vert_reg)
                      * PL_W'($signed({1'b0, inv_tan_reg[RECIP_W-1:0]}));
        s4_f16_reg <= {s3_fwd_reg[D_W-2:0], 16'b0, 1'b0} >> 1;
        s4_pos_reg <= !s3_fwd_reg[D_W-1] && (s3_fwd_reg != '0);
        s4_w_reg   <= s3_virt_reg ? VIRTUAL_W : viewport_reg[2*SIZE_W-1:SIZE_W];
        s4_h_reg   <= s3_virt_reg ? VIRTUAL_H : viewport_reg[SIZE_W-1:0];

        // |p| <= f exactly when 0 <= f - p <= 2f
        s5_ok_reg  <= s4_pos_reg && !tx_full[T_W-1] && !ty_full[T_W-1]
                      && (tx_full <= den_full) && (ty_full <= den_full);
        s5_tx_reg  <= tx_full[REM_W-1:0];
        s5_ty_reg  <= ty_full[REM_W-1:0];
        s5_den_reg <= den_full[REM_W-1:0];
        s5_w_reg   <= s4_w_reg;
        s5_h_reg   <= s4_h_reg;

        sx = div_step('0, '0, s5_tx_reg, s5_den_reg, s5_w_reg[SIZE_W-1]);
        sy = div_step('0, '0, s5_ty_reg, s5_den_reg, s5_h_reg[SIZE_W-1]);
        dv_rx_reg[0]  <= sx[REM_W+SIZE_W-1:SIZE_W];
        dv_qx_reg[0]  <= sx[SIZE_W-1:0];
        dv_ry_reg[0]  <= sy[REM_W+SIZE_W-1:SIZE_W];
        dv_qy_reg[0]  <= sy[SIZE_W-1:0];
        dv_ok_reg[0]  <= s5_ok_reg;
        dv_tx_reg[0]  <= s5_tx_reg;
        dv_ty_reg[0]  <= s5_ty_reg;
        dv_den_reg[0] <= s5_den_reg;
        dv_w_reg[0]   <= s5_w_reg;
        dv_h_reg[0]   <= s5_h_reg;

        for (int i = 1; i < SIZE_W; i++)
        begin
            sx = div_step(dv_rx_reg[i-1], dv_qx_reg[i-1], dv_tx_reg[i-1], dv_den_reg[i-1],
                          dv_w_reg[i-1][SIZE_W-1-i]);
            sy = div_step(dv_ry_reg[i-1], dv_qy_reg[i-1], dv_ty_reg[i-1], dv_den_reg[i-1],
                          dv_h_reg[i-1][SIZE_W-1-i]);
            dv_rx_reg[i]  <= sx[REM_W+SIZE_W-1:SIZE_W];
            dv_qx_reg[i]  <= sx[SIZE_W-1:0];
            dv_ry_reg[i]  <= sy[REM_W+SIZE_W-1:SIZE_W];
            dv_qy_reg[i]  <= sy[SIZE_W-1:0];
            dv_ok_reg[i]  <= dv_ok_reg[i-1];
            dv_tx_reg[i]  <= dv_tx_reg[i-1];
            dv_ty_reg[i]  <= dv_ty_reg[i-1];
            dv_den_reg[i] <= dv_den_reg[i-1];
            dv_w_reg[i]   <= dv_w_reg[i-1];
            dv_h_reg[i]   <= dv_h_reg[i-1];
        end

        out_reg.on_screen <= dv_ok_reg[SIZE_W-1];
        out_reg.screen_x  <= dv_ok_reg[SIZE_W-1]
                             ? SCREEN_BITS'({16'b0, dv_qx_reg[SIZE_W-1]}) : '0;
        out_reg.screen_y  <= dv_ok_reg[SIZE_W-1]
                             ? SCREEN_BITS'({16'b0, dv_qy_reg[SIZE_W-1]}) : '0;
    end

    assign done   = out_valid_reg;
    assign result = out_reg;

    `WPSP_ASSERT_IMPL(a_latency, start, ##LATENCY done)
    `WPSP_ASSERT_IMPL(a_off_zero, done && !result.on_screen, result == '0)
    `WPSP_ASSERT_IMPL(a_div_range_x, s5_valid_reg && s5_ok_reg, s5_tx_reg <= s5_den_reg)
    `WPSP_ASSERT_IMPL(a_div_range_y, s5_valid_reg && s5_ok_reg, s5_ty_reg <= s5_den_reg)
    `WPSP_ASSERT_NEVER(a_never_busy, busy)

endmodule
